@@ sv/assert_macros.svh @@
// Assertion macros shared by the hat-to-button edge event modules.
// Each macro expects clk and rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check conseq in the same cycle as cond.
`define HBE_ASSERT_SAME(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Check conseq in the cycle after cond.
`define HBE_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

@@ sv/hbe_pkg.sv @@
// Types and constants for the hat-to-button edge event block.
// No dependencies; used by every module of the block.
package hbe_pkg;

    localparam int DIRS       = 4;
    localparam int DIR_W      = 2;
    localparam int BUTTON_W   = 8;
    localparam int COUNT_W    = 3;
    localparam int STICK_W    = 2;
    localparam int HAT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int BANK       = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_BASE_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HAT_COUNT_0   = 3'd4;

    typedef struct packed {
        logic [STICK_W-1:0]  stick;
        logic [BUTTON_W-1:0] base;
        logic [DIRS-1:0]     value;
        logic [DIRS-1:0]     changed;
    } job_t;

endpackage

@@ sv/hbe_front.sv @@
// Front end: configuration registers, hat store, edge detection and job push.
// Depends on hbe_pkg.
module hbe_front #(
    parameter int STICKS         = 4,
    parameter int HATS_PER_STICK = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [hbe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hbe_pkg::BUTTON_W-1:0]    cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [hbe_pkg::STICK_W-1:0]     stick_index,
    input  logic [hbe_pkg::HAT_W-1:0]       hat_index,
    input  logic [hbe_pkg::DIRS-1:0]        hat_value,
    input  logic                            queue_full,
    output logic                            push,
    output hbe_pkg::job_t                   push_job
);

    localparam int SLOTS  = STICKS * HATS_PER_STICK;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [hbe_pkg::BUTTON_W-1:0] button_base_reg [hbe_pkg::BANK];
    logic [hbe_pkg::COUNT_W-1:0]  hat_count_reg   [hbe_pkg::BANK];
    logic [hbe_pkg::DIRS-1:0]     hat_store_reg   [SLOTS];

    logic                         accept;
    logic                         present;
    logic [SLOT_W-1:0]            slot;
    logic [hbe_pkg::DIRS-1:0]     old_value;
    logic [hbe_pkg::BUTTON_W-1:0] hat_offset;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        present = (int'(stick_index) < STICKS)
               && (int'(hat_index) < HATS_PER_STICK)
               && ({1'b0, hat_index} < {2'b00, hat_count_reg[stick_index]});
        slot      = present
                  ? SLOT_W'(int'(stick_index) * HATS_PER_STICK + int'(hat_index))
                  : '0;
        old_value = present ? hat_store_reg[slot] : '0;
        hat_offset = {2'b00, hat_index, 2'b00};
        push_job.stick   = stick_index;
        push_job.base    = button_base_reg[stick_index] + hat_offset;
        push_job.value   = hat_value;
        push_job.changed = old_value ^ hat_value;
        push = accept && (push_job.changed != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < hbe_pkg::BANK; i++)
            begin
                button_base_reg[i] <= '0;
                hat_count_reg[i]   <= '0;
            end
        end
        else if (cfg_write)
        begin
            if (cfg_index < hbe_pkg::REG_HAT_COUNT_0)
                button_base_reg[cfg_index[1:0]] <= cfg_data;
            else
                hat_count_reg[cfg_index[1:0]] <= cfg_data[hbe_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                hat_store_reg[i] <= '0;
        end
        else if (accept && present)
        begin
            hat_store_reg[slot] <= hat_value;
        end
    end

endmodule

@@ sv/hbe_queue.sv @@
// Short job queue between the front end and the result sequencer.
// Depends on hbe_pkg and assert_macros.svh.
module hbe_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  hbe_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output hbe_pkg::job_t head
);

    localparam int DEPTH = hbe_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hbe_pkg::job_t    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_job;
    end

    `include "assert_macros.svh"

    `HBE_ASSERT_SAME(a_no_push_full, full, !push, "push into full queue")
    `HBE_ASSERT_SAME(a_no_pop_empty, empty, !pop, "pop from empty queue")

endmodule

@@ sv/hbe_back.sv @@
// Result sequencer: walks the changed direction bits of each job, one beat a cycle unless stalled.
// Depends on hbe_pkg and assert_macros.svh.
module hbe_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          queue_empty,
    input  hbe_pkg::job_t                 head,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hbe_pkg::STICK_W-1:0]   out_stick,
    output logic [hbe_pkg::BUTTON_W-1:0]  button_number,
    output logic                          pressed,
    output logic                          last
);

    logic                         cur_valid_reg, cur_valid_next;
    hbe_pkg::job_t                cur_reg, cur_next;

    logic                         out_valid_reg, out_valid_next;
    logic [hbe_pkg::STICK_W-1:0]  out_stick_reg, out_stick_next;
    logic [hbe_pkg::BUTTON_W-1:0] button_reg, button_next;
    logic                         pressed_reg, pressed_next;
    logic                         last_reg, last_next;

    logic                         emit;
    logic                         finish;
    logic [hbe_pkg::DIR_W-1:0]    sel;
    logic [hbe_pkg::DIRS-1:0]     rem_after;

    always_comb
    begin
        sel = '0;
        for (int i = hbe_pkg::DIRS - 1; i >= 0; i--)
        begin
            if (cur_reg.changed[i])
                sel = hbe_pkg::DIR_W'(i);
        end
        rem_after = cur_reg.changed & ~(hbe_pkg::DIRS'(1) << sel);
        emit   = cur_valid_reg && (!out_valid_reg || out_ready);
        finish = emit && (rem_after == '0);
        pop    = (!cur_valid_reg || finish) && !queue_empty;

        cur_valid_next = cur_valid_reg;
        cur_next       = cur_reg;
        if (pop)
        begin
            cur_valid_next = 1'b1;
            cur_next       = head;
        end
        else if (finish)
        begin
            cur_valid_next = 1'b0;
        end
        else if (emit)
        begin
            cur_next.changed = rem_after;
        end

        out_valid_next = out_valid_reg && !out_ready;
        out_stick_next = out_stick_reg;
        button_next    = button_reg;
        pressed_next   = pressed_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_stick_next = cur_reg.stick;
            button_next    = cur_reg.base + {{(hbe_pkg::BUTTON_W-hbe_pkg::DIR_W){1'b0}}, sel};
            pressed_next   = cur_reg.value[sel];
            last_next      = (rem_after == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        out_stick_reg <= out_stick_next;
        button_reg    <= button_next;
        pressed_reg   <= pressed_next;
        last_reg      <= last_next;
    end

    assign out_valid     = out_valid_reg;
    assign out_stick     = out_stick_reg;
    assign button_number = button_reg;
    assign pressed       = pressed_reg;
    assign last          = last_reg;

    `include "assert_macros.svh"

    `HBE_ASSERT_SAME(a_cur_has_work, cur_valid_reg, cur_reg.changed != '0, "empty job held")
    `HBE_ASSERT_NEXT(a_finish_sets_last, finish, out_valid_reg && last_reg,
                     "final beat of a job without last")

endmodule

@@ sv/hat_to_button_edge_events_unit.sv @@
// Hat-to-button edge events: a hat change in, one button beat per changed direction out.
// An accepted hat event is stored in the job queue, then in the sequencer's current job;
// each output beat is registered. Throughput: one hat event per cycle while the 2-deep
// job queue is not full; the sequencer sends one beat per cycle while out_ready allows.
// Async active-low reset clears the hat store, config registers, queue and valid flags.
module hat_to_button_edge_events_unit #(
    parameter int STICKS         = 4,
    parameter int HATS_PER_STICK = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbe_pkg::BUTTON_W-1:0]  cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hbe_pkg::STICK_W-1:0]   stick_index,
    input  logic [hbe_pkg::HAT_W-1:0]     hat_index,
    input  logic [hbe_pkg::DIRS-1:0]      hat_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [hbe_pkg::STICK_W-1:0]   out_stick,
    output logic [hbe_pkg::BUTTON_W-1:0]  button_number,
    output logic                          pressed,
    output logic                          last
);

    logic          push;
    hbe_pkg::job_t push_job;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;
    hbe_pkg::job_t head;

    hbe_front #(
        .STICKS         (STICKS),
        .HATS_PER_STICK (HATS_PER_STICK)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .stick_index (stick_index),
        .hat_index   (hat_index),
        .hat_value   (hat_value),
        .queue_full  (queue_full),
        .push        (push),
        .push_job    (push_job)
    );

    hbe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    hbe_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .queue_empty   (queue_empty),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_stick     (out_stick),
        .button_number (button_number),
        .pressed       (pressed),
        .last          (last)
    );

endmodule

@@ sim/hat_to_button_edge_events_unit_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the hat-to-button edge event unit: watches the register port and both
// beat channels, predicts the button beats of every accepted hat beat and compares them.
// Depends on hbe_pkg for port widths and register indexes.
module hat_to_button_edge_events_unit_checker #(
    parameter int STICKS         = 4,
    parameter int HATS_PER_STICK = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [hbe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hbe_pkg::BUTTON_W-1:0]  cfg_data,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [hbe_pkg::STICK_W-1:0]   stick_index,
    input  logic [hbe_pkg::HAT_W-1:0]     hat_index,
    input  logic [hbe_pkg::DIRS-1:0]      hat_value,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [hbe_pkg::STICK_W-1:0]   out_stick,
    input  logic [hbe_pkg::BUTTON_W-1:0]  button_number,
    input  logic                          pressed,
    input  logic                          last,
    output int                            mismatch_count,
    output int                            awaited_buttons,
    output int                            hat_beats,
    output int                            button_beats
);

    typedef struct packed {
        logic [hbe_pkg::STICK_W-1:0]  stick;
        logic [hbe_pkg::BUTTON_W-1:0] number;
        logic                         pressed;
        logic                         last;
    } button_event_t;

    button_event_t                expected_buttons [$];
    logic [hbe_pkg::DIRS-1:0]     hat_store [STICKS*HATS_PER_STICK];
    logic [hbe_pkg::BUTTON_W-1:0] stick_base [4];
    logic [hbe_pkg::COUNT_W-1:0]  stick_hats [4];

    function automatic void predict_button_events(
        input logic [hbe_pkg::STICK_W-1:0] s,
        input logic [hbe_pkg::HAT_W-1:0]   h,
        input logic [hbe_pkg::DIRS-1:0]    v
    );
        logic                     present;
        int                       slot;
        int                       top_bit;
        logic [hbe_pkg::DIRS-1:0] prior;
        logic [hbe_pkg::DIRS-1:0] flips;
        button_event_t            ev;
        present = (int'(s) < STICKS) && (int'(h) < HATS_PER_STICK)
            && (h < stick_hats[s]);
        slot = int'(s) * HATS_PER_STICK + int'(h);
        prior = '0;
        if (present)
        begin
            prior = hat_store[slot];
        end
        flips = prior ^ v;
        top_bit = -1;
        for (int b = 0; b < hbe_pkg::DIRS; b++)
        begin
            if (flips[b])
            begin
                top_bit = b;
            end
        end
        for (int b = 0; b < hbe_pkg::DIRS; b++)
        begin
            if (flips[b])
            begin
                ev.stick   = s;
                ev.number  = stick_base[s] + {2'b00, h, 2'b00} + 8'(b);
                ev.pressed = v[b];
                ev.last    = (b == top_bit);
                expected_buttons.push_back(ev);
            end
        end
        if (present)
        begin
            hat_store[slot] = v;
        end
    endfunction

    function automatic void report_field(input string field, input int want, input int seen);
        if (want != seen)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        button_event_t want;
        if (!rst_n)
        begin
            expected_buttons.delete();
            for (int i = 0; i < STICKS*HATS_PER_STICK; i++)
            begin
                hat_store[i] = '0;
            end
            for (int i = 0; i < 4; i++)
            begin
                stick_base[i] = '0;
                stick_hats[i] = '0;
            end
            mismatch_count  = 0;
            awaited_buttons <= 0;
            hat_beats       <= 0;
            button_beats    <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index < hbe_pkg::REG_HAT_COUNT_0)
                begin
                    stick_base[2'(cfg_index - hbe_pkg::REG_BUTTON_BASE_0)] = cfg_data;
                end
                else
                begin
                    stick_hats[2'(cfg_index - hbe_pkg::REG_HAT_COUNT_0)] =
                        cfg_data[hbe_pkg::COUNT_W-1:0];
                end
            end
            if (out_valid && out_ready)
            begin
                button_beats <= button_beats + 1;
                if (expected_buttons.size() == 0)
                begin
                    $display("%0t: button beat with none expected, stick %0d button %0d",
                             $time, out_stick, button_number);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_buttons.pop_front();
                    report_field("out_stick", want.stick, out_stick);
                    report_field("button_number", want.number, button_number);
                    report_field("pressed", want.pressed, pressed);
                    report_field("last", want.last, last);
                end
            end
            if (in_valid && in_ready)
            begin
                hat_beats <= hat_beats + 1;
                predict_button_events(stick_index, hat_index, hat_value);
            end
            awaited_buttons <= expected_buttons.size();
        end
    end

endmodule

@@ sim/hat_to_button_edge_events_unit_test.sv @@
`timescale 1ns / 100ps
// Top of the hat-to-button edge event test: clock, reset, register writes, hat stimulus
// and receiver stalls; instantiates the unit and its checker and gives the verdict.
// Depends on hbe_pkg, hat_to_button_edge_events_unit and the checker module.
module hat_to_button_edge_events_unit_test;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int PHASE_ITEMS   = 25;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [hbe_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hbe_pkg::BUTTON_W-1:0]  cfg_data;
    logic                          in_valid;
    logic                          in_ready;
    logic [hbe_pkg::STICK_W-1:0]   stick_index;
    logic [hbe_pkg::HAT_W-1:0]     hat_index;
    logic [hbe_pkg::DIRS-1:0]      hat_value;
    logic                          out_valid;
    logic                          out_ready;
    logic [hbe_pkg::STICK_W-1:0]   out_stick;
    logic [hbe_pkg::BUTTON_W-1:0]  button_number;
    logic                          pressed;
    logic                          last;

    int mismatch_count;
    int awaited_buttons;
    int hat_beats;
    int button_beats;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    logic [hbe_pkg::BUTTON_W-1:0] cfg_base [4];
    logic [hbe_pkg::COUNT_W-1:0]  cfg_hats [4];

    hat_to_button_edge_events_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .stick_index   (stick_index),
        .hat_index     (hat_index),
        .hat_value     (hat_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_stick     (out_stick),
        .button_number (button_number),
        .pressed       (pressed),
        .last          (last)
    );

    hat_to_button_edge_events_unit_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .stick_index     (stick_index),
        .hat_index       (hat_index),
        .hat_value       (hat_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_stick       (out_stick),
        .button_number   (button_number),
        .pressed         (pressed),
        .last            (last),
        .mismatch_count  (mismatch_count),
        .awaited_buttons (awaited_buttons),
        .hat_beats       (hat_beats),
        .button_beats    (button_beats)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_hat(
        input logic [hbe_pkg::STICK_W-1:0] s,
        input logic [hbe_pkg::HAT_W-1:0]   h,
        input logic [hbe_pkg::DIRS-1:0]    v
    );
        logic taken;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        stick_index <= s;
        hat_index   <= h;
        hat_value   <= v;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (awaited_buttons != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings();
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= hbe_pkg::REG_BUTTON_BASE_0 + 3'(i);
            cfg_data  <= cfg_base[i];
            @(posedge clk);
        end
        for (int i = 0; i < 4; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= hbe_pkg::REG_HAT_COUNT_0 + 3'(i);
            cfg_data  <= 8'(cfg_hats[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_hats(input int count);
        logic [hbe_pkg::STICK_W-1:0] s;
        logic [hbe_pkg::HAT_W-1:0]   h;
        for (int n = 0; n < count; n++)
        begin
            s = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 99) < 80 && cfg_hats[s] != 0)
            begin
                h = 4'($urandom_range(0, cfg_hats[s] - 1));
            end
            else
            begin
                h = 4'($urandom_range(0, 15));
            end
            send_hat(s, h, 4'($urandom_range(0, 15)));
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        stick_index    = '0;
        hat_index      = '0;
        hat_value      = '0;
        out_ready      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers still at reset: no hats, so every set bit presses and nothing is held
        send_hat(2'd0, 4'd0, 4'hF);
        send_hat(2'd0, 4'd0, 4'hF);
        send_hat(2'd3, 4'd15, 4'h0);
        send_hat(2'd1, 4'd0, 4'h5);
        settle();

        cfg_base = '{8'd0, 8'd240, 8'd17, 8'd128};
        cfg_hats = '{3'd4, 3'd4, 3'd2, 3'd0};
        write_settings();
        send_hat(2'd0, 4'd0, 4'h1);
        send_hat(2'd0, 4'd0, 4'h3);
        send_hat(2'd0, 4'd0, 4'hF);
        send_hat(2'd0, 4'd0, 4'h0);
        send_hat(2'd0, 4'd3, 4'h8);
        send_hat(2'd0, 4'd3, 4'h8);
        send_hat(2'd0, 4'd3, 4'h7);
        send_hat(2'd0, 4'd4, 4'hF);
        send_hat(2'd1, 4'd15, 4'hF);
        send_hat(2'd1, 4'd3, 4'hA);
        send_hat(2'd1, 4'd3, 4'h5);
        send_hat(2'd2, 4'd1, 4'h6);
        send_hat(2'd2, 4'd2, 4'h6);
        send_hat(2'd2, 4'd2, 4'h6);
        send_hat(2'd3, 4'd0, 4'h9);
        send_hat(2'd2, 4'd1, 4'h9);
        send_hat(2'd3, 4'd3, 4'h0);

        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            for (int i = 0; i < 4; i++)
            begin
                case (phase)
                    0:
                    begin
                        cfg_base[i] = 8'($urandom_range(0, 240));
                        cfg_hats[i] = 3'd4;
                    end
                    1:
                    begin
                        cfg_base[i] = 8'd240;
                        cfg_hats[i] = 3'd4;
                    end
                    2:
                    begin
                        cfg_base[i] = 8'd0;
                        cfg_hats[i] = 3'($urandom_range(0, 4));
                    end
                    default:
                    begin
                        cfg_base[i] = 8'($urandom_range(0, 240));
                        cfg_hats[i] = 3'($urandom_range(0, 4));
                    end
                endcase
            end
            write_settings();
            send_idle_pct  = (phase == 1) ? 74 : (phase == 3) ? 26 : 0;
            recv_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 26 : 0;
            send_random_hats(PHASE_ITEMS);
        end
        settle();

        $display("Run covered %0d hat beats and %0d button beats", hat_beats, button_beats);
        $display("over five register settings and four idle and stall mixes");
        if (mismatch_count == 0 && awaited_buttons == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("%0d mismatches, %0d button beats never arrived",
                     mismatch_count, awaited_buttons);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
